// ----- hw/rtl/gmo_pkg.sv -----
// Shared types and constants of the gradient magnitude and orientation block.
package gmo_pkg;

  localparam int CFG_W = 10;
  localparam int PIX_W = 8;
  localparam int POS_W = 9;
  localparam int MAG_W = 13;
  localparam int MINMAG_W = 12;
  localparam int ORI_W = 16;
  localparam int KEY_W = 19;
  localparam int SQ_W = 17;

  localparam int DIM_RESET = 512;
  localparam int DIM_MIN = 2;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_BLUR = 1'b0;
  localparam logic OP_EXTREMA = 1'b1;

  localparam logic KIND_GRAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MARK = 8'd255;
  localparam logic [SQ_W-1:0] MIN_SQ_RESET = 17'd65025;
  localparam logic [KEY_W-1:0] KEY_MAX = 19'h7FFFF;
  // Magnitude above a tenth of the maximum: compare squares scaled by 10^2.
  localparam int KEY_SCALE = 100;

  localparam int CW = 32;
  localparam int CORDIC_STEPS = 25;
  localparam int ATAN_Q = 24;
  localparam int CORDIC_PRESCALE = 20;
  localparam logic signed [CW-1:0] PI_Q = 32'sd52707179;
  localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331, 32'sd1047214,
    32'sd524117, 32'sd262123, 32'sd131069, 32'sd65536, 32'sd32768,
    32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
    32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16, 32'sd8, 32'sd4,
    32'sd2, 32'sd1
  };

  typedef struct packed {
    logic opcode;
    logic frame_start;
    logic has_grad;
    logic last_col;
    logic interior;
    logic last_pos;
  } gmo_flags_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ZERO, B_MUL, B_UPD, B_ITER, B_FIN, B_READ, B_KEY,
    B_SMAX, B_WMAX, B_SMIN, B_WMIN, B_OUT
  } gmo_state_t;

endpackage

// ----- hw/rtl/gmo_ifs.sv -----
// Channel interfaces: pixel input, result output and configuration writes.
interface gmo_pixel_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [gmo_pkg::PIX_W-1:0] pixel_value;
  modport source (output valid, opcode, pixel_value, input ready);
  modport sink (input valid, opcode, pixel_value, output ready);
endinterface

interface gmo_result_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [gmo_pkg::POS_W-1:0] out_row;
  logic [gmo_pkg::POS_W-1:0] out_col;
  logic [gmo_pkg::MAG_W-1:0] magnitude;
  logic signed [gmo_pkg::ORI_W-1:0] orientation;
  logic [gmo_pkg::MAG_W-1:0] max_magnitude;
  logic [gmo_pkg::MINMAG_W-1:0] min_magnitude;
  logic [gmo_pkg::KEY_W-1:0] key_count;
  modport source (output valid, result_kind, out_row, out_col, magnitude, orientation,
                  max_magnitude, min_magnitude, key_count, input ready);
  modport sink (input valid, result_kind, out_row, out_col, magnitude, orientation,
                max_magnitude, min_magnitude, key_count, output ready);
endinterface

interface gmo_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [gmo_pkg::CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gmo_queue.sv -----
// Small item queue between the front and back parts.
module gmo_queue #(
  parameter int DW = 8,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [DW-1:0] din,
  input  logic pop,
  output logic [DW-1:0] dout,
  output logic not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PB = $clog2(DEPTH);

  logic [DW-1:0] slots [DEPTH];
  logic [PB-1:0] wp;
  logic [PB-1:0] rp;

  assign dout = slots[rp];
  assign not_empty = (count != '0);

  // Pointers wrap naturally, so DEPTH must be a power of two; the queue does not check this.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + PB'(1);
      if (pop) rp <= rp + PB'(1);
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end
endmodule

// ----- hw/rtl/gmo_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
module gmo_sqrt #(
  parameter int VW = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [VW-1:0] value,
  output logic done,
  output logic [(VW+1)/2-1:0] root
);
  localparam int VWE = VW + (VW % 2);
  localparam int RW = VWE / 2;
  localparam int NB = $clog2(RW + 1);

  logic [VWE-1:0] v;
  logic [RW:0] rem;
  logic [NB-1:0] cnt;
  logic busy;
  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;

  assign rem_sh = {rem, v[VWE-1:VWE-2]};
  assign trial = (RW+3)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == NB'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= VWE'(value);
      rem <= '0;
      root <= '0;
      cnt <= NB'(RW);
    end else if (busy) begin
      v <= v << 2;
      cnt <= cnt - NB'(1);
      if (rem_sh >= trial) begin
        rem <= (RW+1)'(rem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem <= (RW+1)'(rem_sh);
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- hw/rtl/gmo_front.sv -----
// Front part: position tracking, row buffer and item classification.
module gmo_front #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int QDEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  gmo_pixel_if.sink pixels,
  gmo_cfg_if.sink cfg,
  input  logic [$clog2(QDEPTH+1)-1:0] q_count,
  output logic push,
  output gmo_pkg::gmo_flags_t flags,
  output logic [gmo_pkg::PIX_W-1:0] pix,
  output logic [gmo_pkg::PIX_W-1:0] up,
  output logic [gmo_pkg::PIX_W-1:0] right,
  output logic [$clog2(MAX_HEIGHT)-1:0] orow,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] addr
);
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int WB = $clog2(MAX_WIDTH+1);
  localparam int HB = $clog2(MAX_HEIGHT+1);
  localparam int AB = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam logic [WB-1:0] W_RST =
    WB'(MAX_WIDTH < gmo_pkg::DIM_RESET ? MAX_WIDTH : gmo_pkg::DIM_RESET);
  localparam logic [HB-1:0] H_RST =
    HB'(MAX_HEIGHT < gmo_pkg::DIM_RESET ? MAX_HEIGHT : gmo_pkg::DIM_RESET);

  logic [gmo_pkg::PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [CB-1:0] col_q;
  logic [RB-1:0] row_q;
  logic [AB-1:0] lin;
  logic accept;
  logic last_col_c;
  logic last_row_c;
  logic [CB-1:0] col_nx;
  logic [WB-1:0] w_wr;
  logic [HB-1:0] h_wr;

  assign accept = pixels.valid && pixels.ready;
  // One queue slot is kept for the item already in the read stage.
  assign pixels.ready = (int'(q_count) + int'(push)) < QDEPTH;
  assign cfg.ready = 1'b1;

  assign last_col_c = (col_q == CB'(w_eff - WB'(1)));
  assign last_row_c = (row_q == RB'(h_eff - HB'(1)));
  assign col_nx = col_q + CB'(1);

  always_comb begin
    if (int'(cfg.data) < gmo_pkg::DIM_MIN) w_wr = WB'(gmo_pkg::DIM_MIN);
    else if (int'(cfg.data) > MAX_WIDTH) w_wr = WB'(MAX_WIDTH);
    else w_wr = WB'(cfg.data);
    if (int'(cfg.data) < gmo_pkg::DIM_MIN) h_wr = HB'(gmo_pkg::DIM_MIN);
    else if (int'(cfg.data) > MAX_HEIGHT) h_wr = HB'(MAX_HEIGHT);
    else h_wr = HB'(cfg.data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= W_RST;
      h_eff <= H_RST;
      row_q <= '0;
      col_q <= '0;
      lin <= '0;
      push <= 1'b0;
    end else begin
      push <= accept;
      if (cfg.valid) begin
        if (cfg.index == gmo_pkg::REG_WIDTH) w_eff <= w_wr;
        else h_eff <= h_wr;
        row_q <= '0;
        col_q <= '0;
        lin <= '0;
      end else if (accept) begin
        if (last_col_c) begin
          col_q <= '0;
          if (last_row_c) begin
            row_q <= '0;
            lin <= '0;
          end else begin
            row_q <= row_q + RB'(1);
            lin <= lin + AB'(1);
          end
        end else begin
          col_q <= col_nx;
          lin <= lin + AB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags.opcode <= pixels.opcode;
      flags.frame_start <= (row_q == '0) && (col_q == '0);
      flags.has_grad <= (row_q != '0);
      flags.last_col <= last_col_c;
      flags.interior <= !last_row_c && !last_col_c;
      flags.last_pos <= last_row_c && last_col_c;
      pix <= pixels.pixel_value;
      orow <= row_q - RB'(1);
      col <= col_q;
      addr <= (pixels.opcode == gmo_pkg::OP_BLUR) ? lin - AB'(w_eff) : lin;
      up <= row_mem[col_q];
      right <= row_mem[col_nx];
      if (pixels.opcode == gmo_pkg::OP_BLUR) row_mem[col_q] <= pixels.pixel_value;
    end
  end
endmodule

// ----- hw/rtl/gmo_back.sv -----
// Back part: gradient arithmetic, squared-magnitude store, extrema and key count.
module gmo_back #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAG_FRAC_BITS = 4,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  gmo_pkg::gmo_flags_t flags,
  input  logic [gmo_pkg::PIX_W-1:0] pix,
  input  logic [gmo_pkg::PIX_W-1:0] up,
  input  logic [gmo_pkg::PIX_W-1:0] right,
  input  logic [$clog2(MAX_HEIGHT)-1:0] orow,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] addr,
  gmo_result_if.source results
);
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int AB = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SQ_W = gmo_pkg::SQ_W;
  localparam int CW = gmo_pkg::CW;
  localparam int VW = SQ_W + 2 * MAG_FRAC_BITS;
  localparam int RTW = (VW + 1) / 2;
  localparam int SW = $clog2(gmo_pkg::CORDIC_STEPS);
  localparam int SH = gmo_pkg::ATAN_Q - ANGLE_FRAC_BITS;
  localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
  localparam int PW = SQ_W + 7;

  gmo_pkg::gmo_state_t state, state_next;

  logic [SQ_W-1:0] sq_mem [DEPTH];
  logic [gmo_pkg::PIX_W-1:0] e_pix, e_up, e_right;
  logic [RB-1:0] e_orow;
  logic [CB-1:0] e_col;
  logic [AB-1:0] e_addr;
  logic [SQ_W-1:0] max_sq, min_sq, sq_reg, rd_sq;
  logic [gmo_pkg::KEY_W-1:0] key;
  logic signed [8:0] ga, gb;
  logic signed [8:0] a_c, b_c;
  logic signed [17:0] aa, bb;
  logic signed [CW-1:0] xs, ys, z;
  logic signed [CW-1:0] tx, ty, zabs, qm, q;
  logic [SW-1:0] step;
  logic ang_zero;
  logic sq_we;
  logic [SQ_W-1:0] sq_wd;
  logic rt_start, rt_done;
  logic [VW-1:0] rt_val;
  logic [RTW-1:0] rt_root;
  logic [PW-1:0] scaled;

  function automatic logic signed [CW-1:0] sra_tz(input logic signed [CW-1:0] v,
                                                  input logic [SW-1:0] s);
    logic signed [CW-1:0] n;
    n = -v;
    if (v >= 0) return v >>> s;
    return -(n >>> s);
  endfunction

  gmo_sqrt #(.VW(VW)) u_sqrt (
    .clk(clk), .rst(rst), .start(rt_start), .value(rt_val),
    .done(rt_done), .root(rt_root)
  );

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    rt_start = 1'b0;
    rt_val = VW'(sq_reg) << (2 * MAG_FRAC_BITS);
    sq_we = 1'b0;
    sq_wd = sq_reg;
    case (state)
      gmo_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (flags.opcode == gmo_pkg::OP_BLUR) begin
            if (!flags.has_grad) state_next = gmo_pkg::B_IDLE;
            else if (flags.last_col) state_next = gmo_pkg::B_ZERO;
            else state_next = gmo_pkg::B_MUL;
          end else begin
            if (flags.interior && pix == gmo_pkg::PIX_MARK) state_next = gmo_pkg::B_READ;
            else if (flags.last_pos) state_next = gmo_pkg::B_SMAX;
            else state_next = gmo_pkg::B_IDLE;
          end
        end
      end
      gmo_pkg::B_ZERO: begin
        sq_we = 1'b1;
        sq_wd = '0;
        state_next = gmo_pkg::B_OUT;
      end
      gmo_pkg::B_MUL: state_next = gmo_pkg::B_UPD;
      gmo_pkg::B_UPD: begin
        sq_we = 1'b1;
        rt_start = 1'b1;
        state_next = gmo_pkg::B_ITER;
      end
      gmo_pkg::B_ITER: begin
        if (step == SW'(gmo_pkg::CORDIC_STEPS - 1)) state_next = gmo_pkg::B_FIN;
      end
      gmo_pkg::B_FIN: if (rt_done) state_next = gmo_pkg::B_OUT;
      gmo_pkg::B_READ: state_next = gmo_pkg::B_KEY;
      gmo_pkg::B_KEY: state_next = gmo_pkg::B_IDLE;
      gmo_pkg::B_SMAX: begin
        rt_start = 1'b1;
        rt_val = VW'(max_sq) << (2 * MAG_FRAC_BITS);
        state_next = gmo_pkg::B_WMAX;
      end
      gmo_pkg::B_WMAX: if (rt_done) state_next = gmo_pkg::B_SMIN;
      gmo_pkg::B_SMIN: begin
        rt_start = 1'b1;
        rt_val = VW'(min_sq) << (2 * MAG_FRAC_BITS);
        state_next = gmo_pkg::B_WMIN;
      end
      gmo_pkg::B_WMIN: if (rt_done) state_next = gmo_pkg::B_OUT;
      gmo_pkg::B_OUT: if (results.ready) state_next = gmo_pkg::B_IDLE;
      default: state_next = gmo_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gmo_pkg::B_IDLE;
    else state <= state_next;
  end

  assign results.valid = (state == gmo_pkg::B_OUT);

  assign a_c = 9'(signed'({1'b0, e_up})) - 9'(signed'({1'b0, e_pix}));
  assign b_c = 9'(signed'({1'b0, e_up})) - 9'(signed'({1'b0, e_right}));
  assign aa = 18'(a_c) * 18'(a_c);
  assign bb = 18'(b_c) * 18'(b_c);
  assign tx = sra_tz(ys, step);
  assign ty = sra_tz(xs, step);
  assign zabs = (z < 0) ? -z : z;
  assign qm = (zabs + HALF) >>> SH;
  assign q = (z < 0) ? -qm : qm;
  assign scaled = PW'(rd_sq) * PW'(gmo_pkg::KEY_SCALE);

  always_ff @(posedge clk) begin
    if (sq_we) sq_mem[e_addr] <= sq_wd;
    rd_sq <= sq_mem[e_addr];
  end

  // Running extrema and key count.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sq <= '0;
      min_sq <= gmo_pkg::MIN_SQ_RESET;
      key <= '0;
    end else begin
      case (state)
        gmo_pkg::B_IDLE: begin
          if (q_valid && flags.opcode == gmo_pkg::OP_BLUR && flags.frame_start) begin
            max_sq <= '0;
            min_sq <= gmo_pkg::MIN_SQ_RESET;
            key <= '0;
          end
        end
        gmo_pkg::B_UPD: begin
          if (sq_reg > max_sq) max_sq <= sq_reg;
          if (sq_reg < min_sq) min_sq <= sq_reg;
        end
        gmo_pkg::B_KEY: begin
          if (scaled > PW'(max_sq) && key != gmo_pkg::KEY_MAX) key <= key + 1'b1;
        end
        gmo_pkg::B_WMIN: if (rt_done) key <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gmo_pkg::B_IDLE: begin
        e_pix <= pix;
        e_up <= up;
        e_right <= right;
        e_orow <= orow;
        e_col <= col;
        e_addr <= addr;
      end
      gmo_pkg::B_ZERO: begin
        results.result_kind <= gmo_pkg::KIND_GRAD;
        results.out_row <= gmo_pkg::POS_W'(e_orow);
        results.out_col <= gmo_pkg::POS_W'(e_col);
        results.magnitude <= '0;
        results.orientation <= '0;
        results.max_magnitude <= '0;
        results.min_magnitude <= '0;
        results.key_count <= '0;
      end
      gmo_pkg::B_MUL: begin
        sq_reg <= SQ_W'(aa + bb);
        ga <= a_c;
        gb <= b_c;
      end
      gmo_pkg::B_UPD: begin
        // A negative real part is folded into the right half plane first.
        ang_zero <= (ga == 0) && (gb == 0);
        step <= '0;
        if (gb < 0) begin
          z <= (ga >= 0) ? gmo_pkg::PI_Q : -gmo_pkg::PI_Q;
          xs <= -(CW'(gb) <<< gmo_pkg::CORDIC_PRESCALE);
          ys <= -(CW'(ga) <<< gmo_pkg::CORDIC_PRESCALE);
        end else begin
          z <= '0;
          xs <= CW'(gb) <<< gmo_pkg::CORDIC_PRESCALE;
          ys <= CW'(ga) <<< gmo_pkg::CORDIC_PRESCALE;
        end
      end
      gmo_pkg::B_ITER: begin
        step <= step + SW'(1);
        if (ys > 0) begin
          xs <= xs + tx;
          ys <= ys - ty;
          z <= z + gmo_pkg::ATAN_TAB[step];
        end else begin
          xs <= xs - tx;
          ys <= ys + ty;
          z <= z - gmo_pkg::ATAN_TAB[step];
        end
      end
      gmo_pkg::B_FIN: begin
        results.result_kind <= gmo_pkg::KIND_GRAD;
        results.out_row <= gmo_pkg::POS_W'(e_orow);
        results.out_col <= gmo_pkg::POS_W'(e_col);
        results.magnitude <= gmo_pkg::MAG_W'(rt_root);
        results.orientation <= ang_zero ? '0 : gmo_pkg::ORI_W'(q);
        results.max_magnitude <= '0;
        results.min_magnitude <= '0;
        results.key_count <= '0;
      end
      gmo_pkg::B_WMAX: begin
        if (rt_done) results.max_magnitude <= gmo_pkg::MAG_W'(rt_root);
      end
      gmo_pkg::B_WMIN: begin
        if (rt_done) begin
          results.result_kind <= gmo_pkg::KIND_SUMMARY;
          results.out_row <= '0;
          results.out_col <= '0;
          results.magnitude <= '0;
          results.orientation <= '0;
          results.min_magnitude <= gmo_pkg::MINMAG_W'(rt_root);
          results.key_count <= key;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/gradient_magnitude_orientation.sv -----
// Top level of the gradient magnitude and orientation block.
//
//   channel   dir   handshake              payload
//   pixels    in    valid / ready          opcode, pixel_value
//   results   out   valid / ready          result_kind ... key_count
//   cfg       in    valid / ready (=1)     index, data
//
// A gradient item holds the back part for the pop, the multiply, the update,
// 25 steps of the CORDIC loop, rounding and the output; the square root finishes first.
// A summary runs two square roots in turn, plus the pop and output; outputs wait on results.ready.
// A last-column gradient takes the pop, a zero store write and the output; a key candidate
// the pop, a store read and a compare; other items only the pop.
// The front takes one item a cycle until the four-entry queue is full.
// Reset is synchronous on rst; no clearing pass is needed.
module gradient_magnitude_orientation #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAG_FRAC_BITS = 4,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input logic clk,
  input logic rst,
  gmo_pixel_if.sink pixels,
  gmo_result_if.source results,
  gmo_cfg_if.sink cfg
);
  localparam int QDEPTH = 4;
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int AB = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int FB = $bits(gmo_pkg::gmo_flags_t);
  localparam int PW = gmo_pkg::PIX_W;
  localparam int DW = FB + 3 * PW + RB + CB + AB;

  logic push, pop, q_valid;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  gmo_pkg::gmo_flags_t f_flags, b_flags;
  logic [PW-1:0] f_pix, f_up, f_right, b_pix, b_up, b_right;
  logic [RB-1:0] f_orow, b_orow;
  logic [CB-1:0] f_col, b_col;
  logic [AB-1:0] f_addr, b_addr;
  logic [DW-1:0] q_din, q_dout;

  gmo_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .QDEPTH(QDEPTH)) u_front (
    .clk(clk), .rst(rst), .pixels(pixels), .cfg(cfg), .q_count(q_count),
    .push(push), .flags(f_flags), .pix(f_pix), .up(f_up), .right(f_right),
    .orow(f_orow), .col(f_col), .addr(f_addr)
  );

  assign q_din = {f_flags, f_pix, f_up, f_right, f_orow, f_col, f_addr};

  gmo_queue #(.DW(DW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .din(q_din), .pop(pop),
    .dout(q_dout), .not_empty(q_valid), .count(q_count)
  );

  assign {b_flags, b_pix, b_up, b_right, b_orow, b_col, b_addr} = q_dout;

  gmo_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAG_FRAC_BITS(MAG_FRAC_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(pop), .flags(b_flags),
    .pix(b_pix), .up(b_up), .right(b_right), .orow(b_orow), .col(b_col),
    .addr(b_addr), .results(results)
  );
endmodule
